@@ sv/evae_pkg.sv @@
// ----------------------------------------------------------------------------
// evae_pkg
// Shared widths and helpers for the encoder velocity/accel estimator.
// ----------------------------------------------------------------------------
package evae_pkg;

  localparam int POSITION_BITS = 48;
  localparam int TIME_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int ALPHA_BITS    = 17;   // unsigned Q1.16
  localparam int ALPHA_FRAC    = 16;
  localparam int VAL_BITS      = 64;   // filter state, Q.FRACTION_BITS
  localparam int DIFF_BITS     = VAL_BITS + 1;
  localparam int DIV_W         = VAL_BITS + 10;  // |x| * 1000 fits here
  localparam int MUL_W         = VAL_BITS + ALPHA_FRAC;
  localparam int OUT_BITS      = 32;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(65536);

  // x * 1000 as shift and subtract
  function automatic logic [DIV_W-1:0] mul1000(input logic [VAL_BITS-1:0] x);
    logic [DIV_W-1:0] xe;
    begin
      xe = DIV_W'(x);
      mul1000 = (xe << 10) - (xe << 4) - (xe << 3);
    end
  endfunction

  // filtered value >> FRACTION_BITS, truncated toward zero, saturated to int32
  function automatic logic [OUT_BITS-1:0] report(input logic signed [VAL_BITS-1:0] x);
    logic [VAL_BITS-1:0] mag;
    begin
      mag = x[VAL_BITS-1] ? (~x + VAL_BITS'(1)) : x;
      mag = mag >> FRACTION_BITS;
      if (x[VAL_BITS-1]) begin
        if (mag > VAL_BITS'(64'h8000_0000)) mag = VAL_BITS'(64'h8000_0000);
        report = OUT_BITS'(~mag + VAL_BITS'(1));
      end else begin
        if (mag > VAL_BITS'(64'h7FFF_FFFF)) mag = VAL_BITS'(64'h7FFF_FFFF);
        report = OUT_BITS'(mag);
      end
    end
  endfunction

endpackage

@@ sv/evae_div.sv @@
// ----------------------------------------------------------------------------
// evae_div
// Restoring divider, one quotient bit per cycle, quotient saturated at 2^63-1.
// ----------------------------------------------------------------------------
module evae_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [evae_pkg::DIV_W-1:0]    dividend,
  input  logic [evae_pkg::TIME_BITS-1:0] divisor,
  output logic                          done,
  output logic [evae_pkg::VAL_BITS-1:0] quot
);
  import evae_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]     dvd_r;
  logic [TIME_BITS-1:0] rem_r, rem_nxt, dsr_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 run_r, done_r;
  logic [TIME_BITS:0]   trial;
  logic                 qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[DIV_W-1]};
    qbit    = (trial >= {1'b0, dsr_r});
    rem_nxt = qbit ? TIME_BITS'(trial - {1'b0, dsr_r}) : trial[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        dvd_r <= dividend;
        dsr_r <= divisor;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[DIV_W-2:0], qbit};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W-1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = (|dvd_r[DIV_W-1:VAL_BITS-1]) ? {1'b0, {(VAL_BITS-1){1'b1}}}
                                             : {1'b0, dvd_r[VAL_BITS-2:0]};

endmodule

@@ sv/evae_mul.sv @@
// ----------------------------------------------------------------------------
// evae_mul
// Shift-add low-pass step: (base<<16 + alpha*diff + half) >> 16, one bit/cycle.
// ----------------------------------------------------------------------------
module evae_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [evae_pkg::ALPHA_BITS-1:0]     alpha,
  input  logic signed [evae_pkg::DIFF_BITS-1:0] diff,
  input  logic signed [evae_pkg::VAL_BITS-1:0]  base,
  output logic                                done,
  output logic signed [evae_pkg::VAL_BITS-1:0]  result
);
  import evae_pkg::*;

  localparam int CNT_W = $clog2(ALPHA_BITS);

  logic [MUL_W-1:0]      acc_r, b_r;
  logic [ALPHA_BITS-1:0] a_r, a_clamp;
  logic [CNT_W-1:0]      cnt_r;
  logic                  run_r, done_r;

  // alpha above one acts as one
  assign a_clamp = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        a_r   <= a_clamp;
        b_r   <= MUL_W'(diff);
        acc_r <= (MUL_W'(base) << ALPHA_FRAC) + (MUL_W'(1) << (ALPHA_FRAC-1));
      end else if (run_r) begin
        if (a_r[0]) acc_r <= acc_r + b_r;
        b_r   <= b_r << 1;
        a_r   <= a_r >> 1;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ALPHA_BITS-1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = acc_r[MUL_W-1:ALPHA_FRAC];

endmodule

@@ sv/encoder_velocity_accel_estimator_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_velocity_accel_estimator_unit
// Encoder velocity and acceleration estimator with first-order low-pass filters.
// ----------------------------------------------------------------------------
// Takes one beat of {position, ms timestamp} and returns one result beat with
// filtered velocity (counts/s) and acceleration (counts/s^2), both int32
// saturated, plus ready/updated flags. The first beat after reset only primes
// the history; a beat with an unchanged timestamp returns the held values.
// An estimating beat makes two passes through the bit-serial divider (velocity,
// then acceleration) and two passes through the shift-add filter unit, with
// sequencing states between them. Priming and zero-delta beats skip both units
// and go straight to the result. in_tready is high only while the sequencer
// is idle; a finished result waits in the output register while the next
// beat is taken. Alpha registers are Q1.16; values above 1.0 act as 1.0.
// ----------------------------------------------------------------------------
module encoder_velocity_accel_estimator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [47:0] position_count (signed), [79:48] time_ms
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,
  // out_tdata: [31:0] velocity_cps, [63:32] accel_cps2
  // out_tuser: [0] ready_res, [1] updated
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [evae_pkg::ALPHA_BITS-1:0] cfg_wdata
);
  import evae_pkg::*;

  localparam logic CFG_VEL_ALPHA = 1'b0;
  localparam logic CFG_ACC_ALPHA = 1'b1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VPREP  = 4'd1;
  localparam logic [3:0] S_VDIV   = 4'd2;
  localparam logic [3:0] S_VMULGO = 4'd3;
  localparam logic [3:0] S_VMUL   = 4'd4;
  localparam logic [3:0] S_APREP  = 4'd5;
  localparam logic [3:0] S_ADIVGO = 4'd6;
  localparam logic [3:0] S_ADIV   = 4'd7;
  localparam logic [3:0] S_AMULGO = 4'd8;
  localparam logic [3:0] S_AMUL   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r;

  // architectural state
  logic [POSITION_BITS-1:0]   last_pos_r;
  logic [TIME_BITS-1:0]       last_time_r;
  logic                       have_prev_r, est_ready_r;
  logic signed [VAL_BITS-1:0] fv_r, fa_r;
  logic [ALPHA_BITS-1:0]      valpha_r, aalpha_r;

  // per-beat work registers
  logic [POSITION_BITS-1:0]   pos_in_r, d_r;
  logic [TIME_BITS-1:0]       time_in_r, dt_r;
  logic [VAL_BITS-1:0]        mag_r;
  logic                       neg_r;
  logic signed [VAL_BITS-1:0] v_r, fvn_r;
  logic                       rdy_flag_r, upd_flag_r;

  // output register
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [1:0]  out_user_r;

  // shared units
  logic                          div_start, div_done;
  logic [DIV_W-1:0]              div_dvd;
  logic [VAL_BITS-1:0]           div_q;
  logic                          mul_start, mul_done;
  logic [ALPHA_BITS-1:0]         mul_alpha;
  logic signed [DIFF_BITS-1:0]   mul_diff;
  logic signed [VAL_BITS-1:0]    mul_base, mul_res;

  logic                 in_acc;
  logic [TIME_BITS-1:0] dt_in;
  logic [VAL_BITS-1:0]  vmag;
  logic                 out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign dt_in     = in_tdata[79:48] - last_time_r;
  assign out_free  = !out_valid_r || out_tready;

  // position delta magnitude, sign-extended to the filter width
  assign vmag = d_r[POSITION_BITS-1] ? (VAL_BITS'(0) - VAL_BITS'($signed(d_r)))
                                     : VAL_BITS'($signed(d_r));

  always_comb begin
    div_start = (state_r == S_VPREP) || (state_r == S_ADIVGO);
    div_dvd   = (state_r == S_VPREP) ? (mul1000(vmag) << FRACTION_BITS) : mul1000(mag_r);
    mul_start = (state_r == S_VMULGO) || (state_r == S_AMULGO);
    if (state_r == S_VMULGO) begin
      mul_alpha = valpha_r;
      mul_base  = fv_r;
      mul_diff  = DIFF_BITS'(v_r) - DIFF_BITS'(fv_r);
    end else begin
      mul_alpha = aalpha_r;
      mul_base  = fa_r;
      mul_diff  = DIFF_BITS'(v_r) - DIFF_BITS'(fa_r);
    end
  end

  evae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (dt_r),
    .done     (div_done),
    .quot     (div_q)
  );

  evae_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .alpha  (mul_alpha),
    .diff   (mul_diff),
    .base   (mul_base),
    .done   (mul_done),
    .result (mul_res)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valpha_r <= ALPHA_ONE;
      aalpha_r <= ALPHA_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VEL_ALPHA: valpha_r <= cfg_wdata;
        CFG_ACC_ALPHA: aalpha_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      est_ready_r <= 1'b0;
      last_pos_r  <= '0;
      last_time_r <= '0;
      fv_r        <= '0;
      fa_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a free slot, else drop the beat once it is taken
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pos_in_r  <= in_tdata[47:0];
            time_in_r <= in_tdata[79:48];
            dt_r      <= dt_in;
            d_r       <= in_tdata[47:0] - last_pos_r;
            if (!have_prev_r) begin
              // priming beat: store history only
              last_pos_r  <= in_tdata[47:0];
              last_time_r <= in_tdata[79:48];
              have_prev_r <= 1'b1;
              est_ready_r <= 1'b0;
              rdy_flag_r  <= 1'b0;
              upd_flag_r  <= 1'b0;
              state_r     <= S_DONE;
            end else if (dt_in == '0) begin
              rdy_flag_r <= est_ready_r;
              upd_flag_r <= 1'b0;
              state_r    <= S_DONE;
            end else begin
              state_r <= S_VPREP;
            end
          end
        end
        S_VPREP: begin
          neg_r   <= d_r[POSITION_BITS-1];
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          if (div_done) begin
            v_r     <= neg_r ? -$signed(div_q) : $signed(div_q);
            state_r <= S_VMULGO;
          end
        end
        S_VMULGO: state_r <= S_VMUL;
        S_VMUL: begin
          if (mul_done) begin
            fvn_r   <= mul_res;
            state_r <= S_APREP;
          end
        end
        S_APREP: begin
          // change of filtered velocity, as magnitude and sign
          if (fvn_r >= fv_r) begin
            mag_r <= fvn_r - fv_r;
            neg_r <= 1'b0;
          end else begin
            mag_r <= fv_r - fvn_r;
            neg_r <= 1'b1;
          end
          state_r <= S_ADIVGO;
        end
        S_ADIVGO: state_r <= S_ADIV;
        S_ADIV: begin
          if (div_done) begin
            v_r     <= neg_r ? -$signed(div_q) : $signed(div_q);
            state_r <= S_AMULGO;
          end
        end
        S_AMULGO: state_r <= S_AMUL;
        S_AMUL: begin
          if (mul_done) begin
            fa_r        <= mul_res;
            fv_r        <= fvn_r;
            last_pos_r  <= pos_in_r;
            last_time_r <= time_in_r;
            est_ready_r <= 1'b1;
            rdy_flag_r  <= 1'b1;
            upd_flag_r  <= 1'b1;
            state_r     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= {report(fa_r), report(fv_r)};
            out_user_r  <= {upd_flag_r, rdy_flag_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a result beat is never lost: the sequencer only loads a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result overwritten while stalled");

  // an updated beat always reports ready
  a_upd_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[1]) |-> out_user_r[0])
    else $error("updated without ready");

  // estimates only exist once history is primed
  a_ready_prev: assert property (@(posedge clk) disable iff (!rst_n)
    est_ready_r |-> have_prev_r)
    else $error("estimate ready without history");

  // divider needs its full bit-serial pass
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_done)
    else $error("divider finished too early");

endmodule
